>>> rtl/aec_pkg.sv
// Alarm escalation controller package: register map, mode codes and the
// configuration struct shared by the register block, the engine and the top level.
package aec_pkg;

  localparam int CountW = 10;
  localparam int TimerW = 16;
  localparam int DurW   = 8;
  localparam int HourW  = 5;
  localparam int PinW   = 3;
  localparam int ModeW  = 3;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;
  localparam int IdxW   = 3;

  localparam logic [CountW-1:0] COUNT_MAX = 10'd1000;
  localparam logic [TimerW-1:0] TIMER_MAX = 16'hFFFF;

  localparam logic [ModeW-1:0] MODE_OFF        = 3'd0;
  localparam logic [ModeW-1:0] MODE_ARMING     = 3'd1;
  localparam logic [ModeW-1:0] MODE_IDLE       = 3'd2;
  localparam logic [ModeW-1:0] MODE_WARN_PEND  = 3'd3;
  localparam logic [ModeW-1:0] MODE_WARNING    = 3'd4;
  localparam logic [ModeW-1:0] MODE_ALARM_PEND = 3'd5;
  localparam logic [ModeW-1:0] MODE_ALARM      = 3'd6;

  localparam logic [IdxW-1:0] REG_WARN_THR   = 3'd0;
  localparam logic [IdxW-1:0] REG_ALARM_THR  = 3'd1;
  localparam logic [IdxW-1:0] REG_WARN_DUR   = 3'd2;
  localparam logic [IdxW-1:0] REG_ALARM_DUR  = 3'd3;
  localparam logic [IdxW-1:0] REG_DELAYS     = 3'd4;
  localparam logic [IdxW-1:0] REG_PATTERNS   = 3'd5;
  localparam logic [IdxW-1:0] REG_WINDOW     = 3'd6;

  typedef struct packed {
    logic [CountW-1:0] warn_threshold;
    logic [CountW-1:0] alarm_threshold;
    logic [DurW-1:0]   warn_duration;
    logic [DurW-1:0]   alarm_duration;
    logic [23:0]       entry_delays;
    logic [5:0]        output_patterns;
    logic [9:0]        active_window;
  } cfg_t;

endpackage

>>> rtl/aec_regs.sv
// Configuration register block with an APB-style write/read port.
// Depends on aec_pkg for the register map and cfg_t.
module aec_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aec_pkg::AddrW-1:0]  paddr,
  input  logic [aec_pkg::DataW-1:0]  pwdata,
  output logic [aec_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output aec_pkg::cfg_t              cfg
);
  import aec_pkg::*;

  logic            wr_en;
  logic [IdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_threshold  <= 10'd5;
      cfg.alarm_threshold <= 10'd10;
      cfg.warn_duration   <= 8'd1;
      cfg.alarm_duration  <= 8'd1;
      cfg.entry_delays    <= 24'd0;
      cfg.output_patterns <= 6'd57;
      cfg.active_window   <= 10'd0;
    end else if (wr_en) begin
      case (idx)
        REG_WARN_THR:  cfg.warn_threshold  <= pwdata[CountW-1:0];
        REG_ALARM_THR: cfg.alarm_threshold <= pwdata[CountW-1:0];
        REG_WARN_DUR:  cfg.warn_duration   <= pwdata[DurW-1:0];
        REG_ALARM_DUR: cfg.alarm_duration  <= pwdata[DurW-1:0];
        REG_DELAYS:    cfg.entry_delays    <= pwdata[23:0];
        REG_PATTERNS:  cfg.output_patterns <= pwdata[5:0];
        REG_WINDOW:    cfg.active_window   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WARN_THR:  prdata = {22'd0, cfg.warn_threshold};
      REG_ALARM_THR: prdata = {22'd0, cfg.alarm_threshold};
      REG_WARN_DUR:  prdata = {24'd0, cfg.warn_duration};
      REG_ALARM_DUR: prdata = {24'd0, cfg.alarm_duration};
      REG_DELAYS:    prdata = {8'd0, cfg.entry_delays};
      REG_PATTERNS:  prdata = {26'd0, cfg.output_patterns};
      REG_WINDOW:    prdata = {22'd0, cfg.active_window};
      default:       prdata = '0;
    endcase
  end

endmodule

>>> rtl/aec_engine.sv
// Escalation engine: timers, decay divider, event counter, mode machine and pins.
// Updates its state on each beat that advances. Depends on aec_pkg.
module aec_engine #(
  parameter int TIME_SCALE   = 60,
  parameter int DECAY_PERIOD = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  aec_pkg::cfg_t              cfg,
  input  logic                       advance,
  input  logic                       func,
  input  logic                       armed,
  input  logic [aec_pkg::HourW-1:0]  hour,
  output logic [aec_pkg::PinW-1:0]   siren_pins,
  output logic [aec_pkg::ModeW-1:0]  mode,
  output logic [aec_pkg::CountW-1:0] event_count,
  output logic                       in_window
);
  import aec_pkg::*;

  localparam int DivW = (DECAY_PERIOD > 1) ? $clog2(DECAY_PERIOD) : 1;
  localparam logic [DivW-1:0] DIV_LAST  = DivW'(DECAY_PERIOD - 1);
  localparam logic [DurW-1:0] SCALE     = DurW'(TIME_SCALE);

  logic [ModeW-1:0]  mode_reg, mode_reg_next;
  logic [CountW-1:0] event_counter, event_counter_next;
  logic [TimerW-1:0] alarm_timer, alarm_timer_next;
  logic [TimerW-1:0] warning_timer, warning_timer_next;
  logic [TimerW-1:0] arming_timer, arming_timer_next;
  logic [DivW-1:0]   decay_divider, decay_divider_next;
  logic [PinW-1:0]   pin_levels, pin_levels_next;
  logic              window_flag, window_flag_next;

  logic [HourW-1:0]  start_hr, stop_hr;
  logic              active;
  logic              decay_now;
  logic [TimerW-1:0] warn_limit, alarm_limit;
  logic [CountW-1:0] warn_sub, alarm_sub;

  assign start_hr = cfg.active_window[4:0];
  assign stop_hr  = cfg.active_window[9:5];
  assign active   = (stop_hr > start_hr) ? (hour >= start_hr && hour < stop_hr)
                                         : !(hour >= stop_hr && hour < start_hr);

  assign warn_limit  = TimerW'(cfg.warn_duration) * TimerW'(SCALE);
  assign alarm_limit = TimerW'(cfg.alarm_duration) * TimerW'(SCALE);
  assign warn_sub  = (event_counter > cfg.warn_threshold)
                   ? event_counter - cfg.warn_threshold : '0;
  assign alarm_sub = (event_counter > cfg.alarm_threshold)
                   ? event_counter - cfg.alarm_threshold : '0;

  always_comb begin
    mode_reg_next      = mode_reg;
    event_counter_next = event_counter;
    alarm_timer_next   = alarm_timer;
    warning_timer_next = warning_timer;
    arming_timer_next  = arming_timer;
    decay_divider_next = decay_divider;
    pin_levels_next    = pin_levels;
    window_flag_next   = window_flag;
    decay_now          = 1'b0;

    if (advance) begin
      if (func) begin
        if (event_counter < COUNT_MAX) event_counter_next = event_counter + 1'b1;
        else event_counter_next = COUNT_MAX;
      end else begin
        alarm_timer_next   = (alarm_timer == TIMER_MAX) ? TIMER_MAX : alarm_timer + 1'b1;
        warning_timer_next = (warning_timer == TIMER_MAX) ? TIMER_MAX
                                                         : warning_timer + 1'b1;
        arming_timer_next  = (arming_timer == TIMER_MAX) ? TIMER_MAX
                                                        : arming_timer + 1'b1;
        decay_divider_next = (decay_divider >= DIV_LAST) ? '0 : decay_divider + 1'b1;
        decay_now          = (decay_divider_next == '0);

        if (!active) begin
          window_flag_next   = 1'b0;
          event_counter_next = '0;
        end else begin
          window_flag_next = 1'b1;
          case (mode_reg)
            MODE_OFF: begin
              if (armed) begin
                arming_timer_next = '0;
                mode_reg_next     = MODE_ARMING;
              end
            end
            MODE_ARMING: begin
              if (arming_timer_next >= {8'd0, cfg.entry_delays[7:0]})
                mode_reg_next = MODE_IDLE;
            end
            MODE_IDLE: begin
              pin_levels_next = '0;
              if (!armed) begin
                mode_reg_next = MODE_OFF;
              end else if (event_counter >= cfg.alarm_threshold) begin
                alarm_timer_next = '0;
                mode_reg_next    = MODE_ALARM_PEND;
              end else if (event_counter >= cfg.warn_threshold) begin
                warning_timer_next = '0;
                mode_reg_next      = MODE_WARN_PEND;
              end else if (event_counter != '0 && decay_now) begin
                event_counter_next = event_counter - 1'b1;
              end
            end
            MODE_WARN_PEND: begin
              pin_levels_next = '0;
              if (event_counter >= cfg.alarm_threshold) begin
                alarm_timer_next = '0;
                mode_reg_next    = MODE_ALARM_PEND;
              end else if (warning_timer_next >= {8'd0, cfg.entry_delays[15:8]}) begin
                warning_timer_next = '0;
                mode_reg_next      = MODE_WARNING;
              end
            end
            MODE_WARNING: begin
              pin_levels_next = cfg.output_patterns[2:0];
              if (event_counter >= cfg.alarm_threshold) begin
                alarm_timer_next = '0;
                mode_reg_next    = MODE_ALARM_PEND;
              end else if (warning_timer_next >= warn_limit) begin
                event_counter_next = warn_sub;
                warning_timer_next = '0;
                if (warn_sub < cfg.warn_threshold) mode_reg_next = MODE_IDLE;
              end
            end
            MODE_ALARM_PEND: begin
              if (alarm_timer_next >= {8'd0, cfg.entry_delays[23:16]}) begin
                alarm_timer_next = '0;
                mode_reg_next    = MODE_ALARM;
              end
            end
            MODE_ALARM: begin
              pin_levels_next = cfg.output_patterns[5:3];
              if (alarm_timer_next >= alarm_limit) begin
                event_counter_next = alarm_sub;
                if (alarm_sub >= cfg.alarm_threshold) begin
                  alarm_timer_next = '0;
                end else if (alarm_sub >= cfg.warn_threshold) begin
                  warning_timer_next = '0;
                  mode_reg_next      = MODE_WARNING;
                end else begin
                  warning_timer_next = '0;
                  mode_reg_next      = MODE_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_OFF;
      event_counter <= '0;
      alarm_timer   <= '0;
      warning_timer <= '0;
      arming_timer  <= '0;
      decay_divider <= '0;
      pin_levels    <= '0;
      window_flag   <= 1'b0;
    end else begin
      mode_reg      <= mode_reg_next;
      event_counter <= event_counter_next;
      alarm_timer   <= alarm_timer_next;
      warning_timer <= warning_timer_next;
      arming_timer  <= arming_timer_next;
      decay_divider <= decay_divider_next;
      pin_levels    <= pin_levels_next;
      window_flag   <= window_flag_next;
    end
  end

  assign siren_pins  = pin_levels;
  assign mode        = mode_reg;
  assign event_count = event_counter;
  assign in_window   = window_flag;

endmodule

>>> rtl/alarm_escalation_controller.sv
// Alarm escalation controller top level: input register, handshake control,
// configuration registers (aec_regs) and the escalation engine (aec_engine).
//
// Each input beat is a one-second tick (func 0) or an alarm event (func 1) and
// produces exactly one result beat. The block takes one beat per clock while
// item_stall is low: a beat is captured in the input register when accepted and
// the engine updates its state as the beat advances, raising result_valid. The
// engine's state registers double as the result register and hold while a valid
// result is stalled; the input register can take one more beat while a result
// waits, after which item_stall rises. The user must write configuration over
// the APB-style port only while no beat is in flight; this is not enforced.
module alarm_escalation_controller #(
  parameter int TIME_SCALE   = 60,
  parameter int DECAY_PERIOD = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic                       func,
  input  logic                       armed,
  input  logic [aec_pkg::HourW-1:0]  hour,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [aec_pkg::PinW-1:0]   siren_pins,
  output logic [aec_pkg::ModeW-1:0]  mode,
  output logic [aec_pkg::CountW-1:0] event_count,
  output logic                       in_window,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aec_pkg::AddrW-1:0]  paddr,
  input  logic [aec_pkg::DataW-1:0]  pwdata,
  output logic [aec_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import aec_pkg::*;

  cfg_t             cfg;
  logic             s1_valid;
  logic             s1_func;
  logic             s1_armed;
  logic [HourW-1:0] s1_hour;
  logic             advance;
  logic             item_accept;

  assign advance     = s1_valid && (!result_valid || !result_stall);
  assign item_stall  = s1_valid && !advance;
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= item_accept || (s1_valid && !advance);
      result_valid <= advance || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_func  <= func;
      s1_armed <= armed;
      s1_hour  <= hour;
    end
  end

  aec_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aec_engine #(
    .TIME_SCALE   (TIME_SCALE),
    .DECAY_PERIOD (DECAY_PERIOD)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (advance),
    .func        (s1_func),
    .armed       (s1_armed),
    .hour        (s1_hour),
    .siren_pins  (siren_pins),
    .mode        (mode),
    .event_count (event_count),
    .in_window   (in_window)
  );

endmodule
